@@ design/mst_pkg.sv @@
// types and constants shared by the membership set table
`timescale 1ns / 1ps
package mst_pkg;

   localparam int VALUE_W  = 32;
   localparam int COUNT_W  = 7;
   localparam int SPREAD_W = 33;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_SEARCH = 2'd2;

   typedef logic [1:0]                  opcode_type;
   typedef logic signed [VALUE_W-1:0]   value_type;
   typedef logic [COUNT_W-1:0]          count_type;
   typedef logic signed [SPREAD_W-1:0]  spread_type;

   // contents of one cell as seen by its neighbors
   typedef struct packed {
      logic      valid;
      value_type value;
   } nbr_type;

   // per-cycle command broadcast along the row
   typedef struct packed {
      logic look;
      logic ins;
      logic rem;
   } cmd_type;

endpackage

@@ design/mst_req_if.sv @@
// request channel: opcode and value
`timescale 1ns / 1ps
interface mst_req_if;
   import mst_pkg::*;

   logic       valid;
   logic       ready;
   opcode_type opcode;
   value_type  value;

   modport source (output valid, output opcode, output value, input ready);
   modport sink   (input valid, input opcode, input value, output ready);
endinterface

@@ design/mst_rsp_if.sv @@
// response channel: status, count and spread
`timescale 1ns / 1ps
interface mst_rsp_if;
   import mst_pkg::*;

   logic       valid;
   logic       ready;
   logic       success;
   logic       full_reject;
   count_type  element_count;
   logic       is_empty;
   spread_type spread;

   modport source (output valid, output success, output full_reject,
                   output element_count, output is_empty, output spread, input ready);
   modport sink   (input valid, input success, input full_reject,
                   input element_count, input is_empty, input spread, output ready);
endinterface

@@ design/mst_cell.sv @@
// one slot of the sorted row: holds a value and shifts with its neighbors
`timescale 1ns / 1ps
module mst_cell (
   input  logic             clock,
   input  logic             reset,
   input  mst_pkg::value_type key,
   input  mst_pkg::cmd_type cmd,
   input  mst_pkg::nbr_type left,
   input  logic             left_gt,
   input  mst_pkg::nbr_type right,
   output mst_pkg::nbr_type here,
   output logic             gt,
   output logic             eq,
   output mst_pkg::value_type pick
);
   import mst_pkg::*;

   nbr_type cell_ff;
   logic    gt_ff;
   logic    ge_ff;

   assign here = cell_ff;
   assign gt   = gt_ff;
   assign eq   = cell_ff.valid && (cell_ff.value == key);
   // last occupied cell holds the maximum
   assign pick = (cell_ff.valid && !right.valid) ? cell_ff.value : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         gt_ff <= 1'b0;
         ge_ff <= 1'b0;
      end else if (cmd.look) begin
         gt_ff <= !cell_ff.valid || (cell_ff.value > key);
         ge_ff <= cell_ff.valid && (cell_ff.value >= key);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (cmd.ins && gt_ff) begin
         if (left_gt) begin
            cell_ff <= left;
         end else begin
            cell_ff.valid <= 1'b1;
            cell_ff.value <= key;
         end
      end else if (cmd.rem && ge_ff) begin
         cell_ff <= right;
      end
   end

endmodule

@@ design/membership_set_table.sv @@
// membership set table: sorted row of cells with count and spread
//
//  channel | dir | beat
//  --------+-----+------------------------------------------------------------
//  req     | in  | opcode, value
//  rsp     | out | success, full_reject, element_count, is_empty, spread
//
// a request passes from accept to a loaded response register in four steps:
// compare in every cell, shift the row, select min and max, form the spread
// a new request is accepted only after the previous one has loaded its response
// the next request is taken while the previous response still waits
// synchronous reset empties all cells; a stalled rsp holds the row in its last step
`timescale 1ns / 1ps
module membership_set_table #(
   parameter int CAPACITY = 64
) (
   input  logic clock,
   input  logic reset,
   mst_req_if.sink   req_chan,
   mst_rsp_if.source rsp_chan
);
   import mst_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LOOK = 3'd1;
   localparam logic [2:0] ST_EXEC = 3'd2;
   localparam logic [2:0] ST_PICK = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]      state_ff, state_in;
   opcode_type      op_ff;
   value_type       key_ff;
   logic            hit_ff;
   logic [CW-1:0]   count_ff, count_in;
   logic            success_ff, reject_ff, empty_ff;
   value_type       max_ff, min_ff;

   logic            rsp_valid_ff;
   logic            rsp_success_ff, rsp_reject_ff, rsp_empty_ff;
   count_type       rsp_count_ff;
   spread_type      rsp_spread_ff;

   cmd_type         cmd;
   nbr_type         cells [CAPACITY];
   logic [CAPACITY-1:0] gt_vec;
   logic [CAPACITY-1:0] eq_vec;
   value_type       pick_vec [CAPACITY];
   logic [CAPACITY-1:0] pick_bits [VALUE_W];
   value_type       max_sel;

   logic            accept;
   logic            load_rsp;
   logic            room;
   logic            do_ins, do_rem;

   assign accept   = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign load_rsp = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_chan.ready);
   assign room     = (count_ff < CW'(CAPACITY));
   assign do_ins   = (op_ff == OP_INSERT) && !hit_ff && room;
   assign do_rem   = (op_ff == OP_REMOVE) && hit_ff;

   assign cmd.look = (state_ff == ST_LOOK);
   assign cmd.ins  = (state_ff == ST_EXEC) && do_ins;
   assign cmd.rem  = (state_ff == ST_EXEC) && do_rem;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      nbr_type left_n, right_n;
      logic    left_gt_n;

      if (i == 0) begin : g_first
         assign left_n    = '{valid: 1'b0, value: '0};
         assign left_gt_n = 1'b0;
      end else begin : g_mid
         assign left_n    = cells[i-1];
         assign left_gt_n = gt_vec[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_n = '{valid: 1'b0, value: '0};
      end else begin : g_inner
         assign right_n = cells[i+1];
      end

      mst_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .key     (key_ff),
         .cmd     (cmd),
         .left    (left_n),
         .left_gt (left_gt_n),
         .right   (right_n),
         .here    (cells[i]),
         .gt      (gt_vec[i]),
         .eq      (eq_vec[i]),
         .pick    (pick_vec[i])
      );

      for (genvar b = 0; b < VALUE_W; b++) begin : g_bit
         assign pick_bits[b][i] = pick_vec[i][b];
      end
   end

   for (genvar b = 0; b < VALUE_W; b++) begin : g_max
      assign max_sel[b] = |pick_bits[b];
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_LOOK;
         ST_LOOK: state_in = ST_EXEC;
         ST_EXEC: begin
            state_in = ST_PICK;
            if (do_ins) count_in = count_ff + CW'(1);
            else if (do_rem) count_in = count_ff - CW'(1);
         end
         ST_PICK: state_in = ST_DONE;
         ST_DONE: if (load_rsp) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (load_rsp) rsp_valid_ff <= 1'b1;
         else if (rsp_chan.ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_chan.opcode;
         key_ff <= req_chan.value;
      end
      if (state_ff == ST_LOOK) hit_ff <= |eq_vec;
      if (state_ff == ST_EXEC) begin
         success_ff <= do_ins || do_rem || ((op_ff == OP_SEARCH) && hit_ff);
         reject_ff  <= (op_ff == OP_INSERT) && !hit_ff && !room;
      end
      if (state_ff == ST_PICK) begin
         max_ff   <= max_sel;
         min_ff   <= cells[0].value;
         empty_ff <= (count_ff == '0);
      end
      if (load_rsp) begin
         rsp_success_ff <= success_ff;
         rsp_reject_ff  <= reject_ff;
         rsp_count_ff   <= COUNT_W'(count_ff);
         rsp_empty_ff   <= empty_ff;
         rsp_spread_ff  <= empty_ff ? '1
                         : ($signed({max_ff[VALUE_W-1], max_ff})
                            - $signed({min_ff[VALUE_W-1], min_ff}));
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.success       = rsp_success_ff;
   assign rsp_chan.full_reject   = rsp_reject_ff;
   assign rsp_chan.element_count = rsp_count_ff;
   assign rsp_chan.is_empty      = rsp_empty_ff;
   assign rsp_chan.spread        = rsp_spread_ff;

endmodule

@@ design/mst_checker.sv @@
// port-level checks for the membership set table and their binding
`timescale 1ns / 1ps
module mst_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 rsp_success,
   input logic                 rsp_full_reject,
   input mst_pkg::count_type   rsp_element_count,
   input logic                 rsp_is_empty,
   input mst_pkg::spread_type  rsp_spread
);
   import mst_pkg::*;

   // stalled beat holds its valid, spread, count and success
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_spread)
         && $stable(rsp_element_count) && $stable(rsp_success))
      else $error("rsp beat changed while stalled");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> rsp_element_count == '0)
      else $error("empty set with nonzero count");

   // spread is negative exactly when the set is empty
   a_empty_spread: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_is_empty == rsp_spread[SPREAD_W-1])
      else $error("spread sign disagrees with empty flag");

   a_reject_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_full_reject |-> !rsp_success)
      else $error("rejected insert reported as success");

endmodule

bind membership_set_table mst_checker u_mst_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_success       (rsp_chan.success),
   .rsp_full_reject   (rsp_chan.full_reject),
   .rsp_element_count (rsp_chan.element_count),
   .rsp_is_empty      (rsp_chan.is_empty),
   .rsp_spread        (rsp_chan.spread)
);

@@ sim/tb_membership_set_table.sv @@
// testbench for the membership set table: directed, capacity, backpressure and random tests
`timescale 1ns / 1ps
module tb_membership_set_table;
   import mst_pkg::*;

   localparam int CAPACITY         = 64;
   localparam int SETTLE_CYCLES    = 20;
   localparam int STALL_LIMIT      = 4000;
   localparam int RSP_HOLD_CYCLES  = 400;
   localparam int POOL_SIZE        = 48;
   localparam opcode_type OP_NONE  = 2'd3;

   typedef struct {
      logic       success;
      logic       full_reject;
      count_type  element_count;
      logic       is_empty;
      spread_type spread;
   } status_type;

   logic clock;
   logic reset;

   mst_req_if req_bus ();
   mst_rsp_if rsp_bus ();

   membership_set_table #(
      .CAPACITY(CAPACITY)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus)
   );

   // shadow copy of the set
   value_type set_vals [CAPACITY];
   logic      set_used [CAPACITY];
   int        set_size;

   status_type pending_status [$];
   int         mismatch_count;
   int         idle_cycles;
   int         rsp_hold_left;
   logic       req_idle_on;
   logic       rsp_idle_on;
   value_type  hot_pool [POOL_SIZE];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic status_type apply_set_op(input opcode_type op, input value_type val);
      status_type st;
      int         hit;
      int         free_idx;
      logic       any;
      value_type  lo;
      value_type  hi;
      hit = -1;
      free_idx = -1;
      st.success = 1'b0;
      st.full_reject = 1'b0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (set_used[i] && set_vals[i] == val && hit < 0)
            hit = i;
         if (!set_used[i] && free_idx < 0)
            free_idx = i;
      end
      case (op)
         OP_INSERT: begin
            if (hit < 0) begin
               if (free_idx < 0) begin
                  st.full_reject = 1'b1;
               end else begin
                  set_vals[free_idx] = val;
                  set_used[free_idx] = 1'b1;
                  set_size++;
                  st.success = 1'b1;
               end
            end
         end
         OP_REMOVE: begin
            if (hit >= 0) begin
               set_used[hit] = 1'b0;
               set_size--;
               st.success = 1'b1;
            end
         end
         OP_SEARCH: begin
            st.success = (hit >= 0);
         end
         default: begin
         end
      endcase
      any = 1'b0;
      lo = '0;
      hi = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (set_used[i]) begin
            if (!any || set_vals[i] < lo)
               lo = set_vals[i];
            if (!any || set_vals[i] > hi)
               hi = set_vals[i];
            any = 1'b1;
         end
      end
      st.element_count = count_type'(set_size);
      st.is_empty = (set_size == 0);
      st.spread = any ? spread_type'({hi[VALUE_W-1], hi} - {lo[VALUE_W-1], lo}) : '1;
      return st;
   endfunction

   function automatic value_type pick_stored_value();
      int idx [$];
      for (int i = 0; i < CAPACITY; i++) begin
         if (set_used[i])
            idx.push_back(i);
      end
      if (idx.size() == 0)
         return value_type'($urandom);
      return set_vals[idx[$urandom_range(0, idx.size() - 1)]];
   endfunction

   task automatic send_request(input opcode_type op, input value_type val);
      int unsigned gap;
      gap = req_idle_on ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.opcode <= op;
      req_bus.value  <= val;
      do @(posedge clock); while (!req_bus.ready);
      pending_status.push_back(apply_set_op(op, val));
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_status.size() != 0);
   endtask

   task automatic test_directed();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      send_request(OP_SEARCH, 32'sd0);
      send_request(OP_REMOVE, 32'sd5);
      send_request(OP_NONE, 32'sd0);
      send_request(OP_INSERT, 32'sh8000_0000);
      send_request(OP_INSERT, 32'sh7fff_ffff);
      send_request(OP_SEARCH, 32'sh8000_0000);
      send_request(OP_SEARCH, 32'sh7fff_ffff);
      send_request(OP_INSERT, 32'sh7fff_ffff);
      send_request(OP_SEARCH, 32'sd0);
      send_request(OP_INSERT, -32'sd1);
      send_request(OP_INSERT, 32'sd0);
      send_request(OP_NONE, 32'sd123);
      send_request(OP_REMOVE, 32'sh8000_0000);
      send_request(OP_REMOVE, 32'sh8000_0000);
      send_request(OP_REMOVE, 32'sh7fff_ffff);
      send_request(OP_REMOVE, -32'sd1);
      send_request(OP_REMOVE, 32'sd0);
      send_request(OP_INSERT, 32'sh5555_5555);
      send_request(OP_INSERT, 32'shaaaa_aaaa);
      send_request(OP_NONE, 32'shffff_ffff);
      send_request(OP_REMOVE, 32'sh5555_5555);
      send_request(OP_REMOVE, 32'shaaaa_aaaa);
      send_request(OP_SEARCH, 32'shaaaa_aaaa);
   endtask

   task automatic test_capacity_limit();
      value_type base;
      value_type step;
      base = value_type'($urandom);
      step = value_type'($urandom) | 32'sd1;
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b0;
      for (int i = 0; i < CAPACITY; i++)
         send_request(OP_INSERT, base + step * i);
      send_request(OP_INSERT, base + step * CAPACITY);
      send_request(OP_INSERT, base + step * 3);
      send_request(OP_SEARCH, base + step * 5);
      send_request(OP_NONE, base);
      send_request(OP_REMOVE, base + step * 17);
      send_request(OP_INSERT, base + step * CAPACITY);
      send_request(OP_INSERT, base + step * (CAPACITY + 1));
      rsp_idle_on = 1'b1;
      while (set_size > 0)
         send_request(OP_REMOVE, pick_stored_value());
      send_request(OP_SEARCH, base);
   endtask

   task automatic test_backpressure();
      int r;
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      rsp_hold_left = RSP_HOLD_CYCLES;
      repeat (48) begin
         r = $urandom_range(0, 2);
         send_request(r == 0 ? OP_INSERT : (r == 1 ? OP_REMOVE : OP_SEARCH),
                      value_type'(int'($urandom_range(0, 15)) - 8));
      end
      wait_drained();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      repeat (8)
         send_request(OP_REMOVE, pick_stored_value());
      wait_drained();
   endtask

   task automatic test_random_mix();
      int         r;
      int         ins_pct;
      int         rem_pct;
      opcode_type op;
      value_type  val;
      hot_pool[0] = 32'sh8000_0000;
      hot_pool[1] = 32'sh7fff_ffff;
      hot_pool[2] = 32'sd0;
      hot_pool[3] = -32'sd1;
      for (int i = 4; i < POOL_SIZE; i++)
         hot_pool[i] = (i % 2) ? value_type'($urandom)
                               : value_type'(int'($urandom_range(0, 40)) - 20);
      for (int phase = 0; phase < 15; phase++) begin
         case (phase % 3)
            0: begin ins_pct = 65; rem_pct = 15; end
            1: begin ins_pct = 15; rem_pct = 60; end
            default: begin ins_pct = 40; rem_pct = 30; end
         endcase
         req_idle_on = (phase % 4 == 0) || (phase % 4 == 1);
         rsp_idle_on = (phase % 4 == 0) || (phase % 4 == 2);
         repeat (100) begin
            r = $urandom_range(0, 99);
            if (r < ins_pct)
               op = OP_INSERT;
            else if (r < ins_pct + rem_pct)
               op = OP_REMOVE;
            else if (r < 97)
               op = OP_SEARCH;
            else
               op = OP_NONE;
            r = $urandom_range(0, 99);
            if (op == OP_INSERT)
               val = (r < 55) ? hot_pool[$urandom_range(0, POOL_SIZE - 1)]
                              : value_type'($urandom);
            else if (r < 60 && set_size > 0)
               val = pick_stored_value();
            else if (r < 85)
               val = hot_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
               val = value_type'($urandom);
            send_request(op, val);
         end
      end
   endtask

   // response sink with per-beat idle draws and a long hold on request
   initial begin : rsp_drain
      int unsigned wait_left;
      wait_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_bus.ready <= 1'b0;
            wait_left = 0;
         end else begin
            if (rsp_bus.valid && rsp_bus.ready)
               wait_left = rsp_idle_on ? $urandom_range(0, 15) : 0;
            else if (wait_left > 0)
               wait_left--;
            if (rsp_hold_left > 0) begin
               rsp_hold_left--;
               rsp_bus.ready <= 1'b0;
            end else begin
               rsp_bus.ready <= (wait_left == 0);
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      status_type want;
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end else if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_status.size() == 0) begin
               $error("response beat with no request outstanding");
               mismatch_count++;
            end else begin
               want = pending_status.pop_front();
               if (rsp_bus.success !== want.success) begin
                  $error("success: expected %0d, got %0d", want.success, rsp_bus.success);
                  mismatch_count++;
               end
               if (rsp_bus.full_reject !== want.full_reject) begin
                  $error("full_reject: expected %0d, got %0d",
                         want.full_reject, rsp_bus.full_reject);
                  mismatch_count++;
               end
               if (rsp_bus.element_count !== want.element_count) begin
                  $error("element_count: expected %0d, got %0d",
                         want.element_count, rsp_bus.element_count);
                  mismatch_count++;
               end
               if (rsp_bus.is_empty !== want.is_empty) begin
                  $error("is_empty: expected %0d, got %0d", want.is_empty, rsp_bus.is_empty);
                  mismatch_count++;
               end
               if (rsp_bus.spread !== want.spread) begin
                  $error("spread: expected %0d, got %0d", want.spread, rsp_bus.spread);
                  mismatch_count++;
               end
            end
         end
      end
   end

   initial begin
      mismatch_count = 0;
      idle_cycles = 0;
      rsp_hold_left = 0;
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      set_size = 0;
      for (int i = 0; i < CAPACITY; i++) begin
         set_used[i] = 1'b0;
         set_vals[i] = '0;
      end
      reset          <= 1'b1;
      req_bus.valid  <= 1'b0;
      req_bus.opcode <= OP_INSERT;
      req_bus.value  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_capacity_limit();
      test_backpressure();
      test_random_mix();

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

@@ files.f @@
design/mst_pkg.sv
design/mst_req_if.sv
design/mst_rsp_if.sv
design/mst_cell.sv
design/membership_set_table.sv
design/mst_checker.sv
sim/tb_membership_set_table.sv
